/* rtl/core/synth_voice_allocator_assert.svh */
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Shared wrappers for concurrent checks; clk and rst_n come from the user.
// ----------------------------------------------------------------------------
`ifndef SYNTH_VOICE_ALLOCATOR_ASSERT_SVH
`define SYNTH_VOICE_ALLOCATOR_ASSERT_SVH

// check that is masked while reset is asserted
`define SVALLOC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds while reset is asserted
`define SVALLOC_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/svalloc_pkg.sv */
// ----------------------------------------------------------------------------
// svalloc_pkg
// Types, widths and codes shared by the voice allocator modules.
// ----------------------------------------------------------------------------
package svalloc_pkg;

    localparam int VOICES  = 6;
    localparam int SLOT_W  = $clog2(VOICES);
    localparam int VOICE_W = 3;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int KIND_W  = 2;

    localparam logic [KIND_W-1:0] KIND_RELEASED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRESSED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HELD     = 2'd2;

    // configuration register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VELOCITY = 1'd1;

    typedef struct packed {
        logic              key_down;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
    } key_event_t;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [KIND_W-1:0]  event_kind;
        logic [NOTE_W-1:0]  out_note;
        logic [VEL_W-1:0]   out_velocity;
    } voice_event_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
    } slot_t;

    // classified command handed from front to back
    typedef struct packed {
        logic              press;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
    } cmd_t;

endpackage

/* rtl/core/svalloc_front.sv */
// ----------------------------------------------------------------------------
// svalloc_front
// Accepts key events, drops soft presses, queues commands for the back end.
// ----------------------------------------------------------------------------
module svalloc_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  svalloc_pkg::key_event_t  key_event,
    input  logic [6:0]               min_velocity,
    output logic                     cmd_valid,
    output svalloc_pkg::cmd_t        cmd,
    input  logic                     cmd_take
);
    import svalloc_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             queue_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             transfer;
    logic             soft_press;
    logic             enq;
    logic             deq;
    cmd_t             new_cmd;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign transfer   = push && !full;
    // a press that does not beat the threshold changes nothing
    assign soft_press = key_event.key_down && (key_event.velocity <= min_velocity);
    assign enq        = transfer && !soft_press;
    assign cmd_valid  = (count_reg != '0);
    assign deq        = cmd_valid && cmd_take;
    assign cmd        = queue_reg[rd_ptr_reg];

    assign new_cmd.press    = key_event.key_down;
    assign new_cmd.note     = key_event.note;
    assign new_cmd.velocity = key_event.velocity;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!enq && deq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

/* rtl/core/svalloc_back.sv */
// ----------------------------------------------------------------------------
// svalloc_back
// Walks the slot table once per command, then updates it and posts a result if the command gives one.
// ----------------------------------------------------------------------------
module svalloc_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    input  svalloc_pkg::cmd_t          cmd,
    output logic                       cmd_take,
    input  logic                       mono_mode,
    output logic                       empty,
    input  logic                       pop,
    output svalloc_pkg::voice_event_t  voice_event
);
    import svalloc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(VOICES - 1);

    // what one walk over the table collects
    typedef struct packed {
        logic              pm_f;    // first pressed slot with the note
        logic [SLOT_W-1:0] pm_i;
        logic              am_f;    // first sounding (pressed or held) slot with the note
        logic [SLOT_W-1:0] am_i;
        logic              fh_f;    // first non-pressed slot at or after the pointer
        logic [SLOT_W-1:0] fh_i;
        logic              fl_f;    // first non-pressed slot before the pointer
        logic [SLOT_W-1:0] fl_i;
        logic              pk_f;    // first released parking slot
        logic [SLOT_W-1:0] pk_i;
        logic              bh_f;    // held parking slot with the highest note
        logic [SLOT_W-1:0] bh_i;
        logic [NOTE_W-1:0] bh_note;
        logic [VEL_W-1:0]  bh_vel;
    } scan_t;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;
    logic [SLOT_W-1:0] next_slot_reg;
    logic [SLOT_W-1:0] next_slot_next;
    scan_t             scan_reg;
    scan_t             scan_next;
    cmd_t              cmd_reg;
    slot_t             slot_reg [VOICES];
    voice_event_t      out_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    slot_t             cur;
    slot_t             s0;
    logic              note_hit;
    logic              out_free;
    logic              commit;

    logic              wa_en;
    logic [SLOT_W-1:0] wa_idx;
    slot_t             wa_data;
    logic              w0_en;
    slot_t             w0_data;
    logic              emit;
    voice_event_t      res;
    logic              ptr_upd;
    logic [SLOT_W-1:0] chosen;

    assign cur         = slot_reg[idx_reg];
    assign s0          = slot_reg[0];
    assign note_hit    = (cur.note == cmd_reg.note);
    assign out_free    = !out_valid_reg || pop;
    assign empty       = !out_valid_reg;
    assign voice_event = out_reg;

    // sequencer and walk
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        scan_next  = scan_reg;
        cmd_take   = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_take = cmd_valid;
                if (cmd_valid)
                begin
                    scan_next  = '0;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!scan_reg.pm_f && cur.kind == KIND_PRESSED && note_hit)
                begin
                    scan_next.pm_f = 1'b1;
                    scan_next.pm_i = idx_reg;
                end
                if (!scan_reg.am_f && cur.kind != KIND_RELEASED && note_hit)
                begin
                    scan_next.am_f = 1'b1;
                    scan_next.am_i = idx_reg;
                end
                if (cur.kind != KIND_PRESSED)
                begin
                    if (idx_reg >= next_slot_reg)
                    begin
                        if (!scan_reg.fh_f)
                        begin
                            scan_next.fh_f = 1'b1;
                            scan_next.fh_i = idx_reg;
                        end
                    end
                    else if (!scan_reg.fl_f)
                    begin
                        scan_next.fl_f = 1'b1;
                        scan_next.fl_i = idx_reg;
                    end
                end
                if (idx_reg != '0)
                begin
                    if (!scan_reg.pk_f && cur.kind == KIND_RELEASED)
                    begin
                        scan_next.pk_f = 1'b1;
                        scan_next.pk_i = idx_reg;
                    end
                    // strict compare keeps the lowest index on a tie
                    if (cur.kind == KIND_HELD && (!scan_reg.bh_f || cur.note > scan_reg.bh_note))
                    begin
                        scan_next.bh_f    = 1'b1;
                        scan_next.bh_i    = idx_reg;
                        scan_next.bh_note = cur.note;
                        scan_next.bh_vel  = cur.velocity;
                    end
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // table update and result for the walked command
    always_comb
    begin
        wa_en          = 1'b0;
        wa_idx         = '0;
        wa_data        = '0;
        w0_en          = 1'b0;
        w0_data        = '0;
        emit           = 1'b0;
        res            = '0;
        ptr_upd        = 1'b0;
        chosen         = next_slot_reg;
        next_slot_next = next_slot_reg;

        if (!mono_mode)
        begin
            if (scan_reg.fh_f)
            begin
                chosen = scan_reg.fh_i;
            end
            else if (scan_reg.fl_f)
            begin
                chosen = scan_reg.fl_i;
            end
            if (scan_reg.pm_f)
            begin
                wa_en   = 1'b1;
                wa_idx  = scan_reg.pm_i;
                wa_data = '{kind: cmd_reg.press ? KIND_PRESSED : KIND_RELEASED,
                            note: cmd_reg.note, velocity: cmd_reg.velocity};
                emit    = 1'b1;
                res     = '{voice: VOICE_W'(scan_reg.pm_i), event_kind: wa_data.kind,
                            out_note: cmd_reg.note, out_velocity: cmd_reg.velocity};
            end
            else if (cmd_reg.press)
            begin
                // round robin; with every slot pressed the pointer's own slot is taken
                wa_en   = 1'b1;
                wa_idx  = chosen;
                wa_data = '{kind: KIND_PRESSED, note: cmd_reg.note,
                            velocity: cmd_reg.velocity};
                emit    = 1'b1;
                res     = '{voice: VOICE_W'(chosen), event_kind: KIND_PRESSED,
                            out_note: cmd_reg.note, out_velocity: cmd_reg.velocity};
                ptr_upd = 1'b1;
            end
        end
        else if (cmd_reg.press)
        begin
            if (s0.kind == KIND_PRESSED || s0.kind == KIND_HELD)
            begin
                if (s0.note < cmd_reg.note)
                begin
                    // new top note: park the old one, voice 0 takes over without retrigger
                    wa_en   = scan_reg.pk_f;
                    wa_idx  = scan_reg.pk_i;
                    wa_data = '{kind: KIND_HELD, note: s0.note, velocity: s0.velocity};
                    w0_en   = 1'b1;
                    w0_data = '{kind: KIND_HELD, note: cmd_reg.note,
                                velocity: cmd_reg.velocity};
                    emit    = 1'b1;
                    res     = '{voice: '0, event_kind: KIND_HELD,
                                out_note: cmd_reg.note, out_velocity: cmd_reg.velocity};
                end
                else if (s0.note > cmd_reg.note)
                begin
                    wa_en   = scan_reg.pk_f;
                    wa_idx  = scan_reg.pk_i;
                    wa_data = '{kind: KIND_HELD, note: cmd_reg.note,
                                velocity: cmd_reg.velocity};
                end
            end
            else
            begin
                w0_en   = 1'b1;
                w0_data = '{kind: KIND_PRESSED, note: cmd_reg.note,
                            velocity: cmd_reg.velocity};
                emit    = 1'b1;
                res     = '{voice: '0, event_kind: KIND_PRESSED,
                            out_note: cmd_reg.note, out_velocity: cmd_reg.velocity};
            end
        end
        else if (scan_reg.am_f)
        begin
            if (scan_reg.am_i == '0)
            begin
                if (scan_reg.bh_f)
                begin
                    // highest parked note falls back onto voice 0
                    wa_en   = 1'b1;
                    wa_idx  = scan_reg.bh_i;
                    wa_data = '{kind: KIND_RELEASED, note: scan_reg.bh_note,
                                velocity: scan_reg.bh_vel};
                    w0_en   = 1'b1;
                    w0_data = '{kind: KIND_HELD, note: scan_reg.bh_note,
                                velocity: scan_reg.bh_vel};
                    emit    = 1'b1;
                    res     = '{voice: '0, event_kind: KIND_HELD,
                                out_note: scan_reg.bh_note, out_velocity: scan_reg.bh_vel};
                end
                else
                begin
                    w0_en   = 1'b1;
                    w0_data = '{kind: KIND_RELEASED, note: cmd_reg.note,
                                velocity: cmd_reg.velocity};
                    emit    = 1'b1;
                    res     = '{voice: '0, event_kind: KIND_RELEASED,
                                out_note: cmd_reg.note, out_velocity: cmd_reg.velocity};
                end
            end
            else
            begin
                wa_en   = 1'b1;
                wa_idx  = scan_reg.am_i;
                wa_data = '{kind: KIND_RELEASED, note: cmd_reg.note,
                            velocity: cmd_reg.velocity};
            end
        end

        if (ptr_upd)
        begin
            next_slot_next = (chosen == LAST_IDX) ? '0 : chosen + 1'b1;
        end
    end

    assign out_valid_next = (out_valid_reg && !pop) || (commit && emit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            next_slot_reg <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < VOICES; i++)
            begin
                slot_reg[i] <= '{kind: KIND_RELEASED, note: '0, velocity: '0};
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                next_slot_reg <= next_slot_next;
                for (int i = 0; i < VOICES; i++)
                begin
                    if (wa_en && wa_idx == SLOT_W'(i))
                    begin
                        slot_reg[i] <= wa_data;
                    end
                end
                if (w0_en)
                begin
                    slot_reg[0] <= w0_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg <= cmd;
        end
        if (commit && emit)
        begin
            out_reg <= res;
        end
    end

endmodule

/* rtl/core/synth_voice_allocator.sv */
// ----------------------------------------------------------------------------
// synth_voice_allocator
// Key press/release events in, voice events out (round robin or mono priority).
// Input queue: push/full; a transfer happens when push is high and full low.
// Result queue: the oldest voice event sits on voice_event while empty is low;
// it is taken when pop is high and empty low. A key event gives one or no result.
// Config: cfg_we writes cfg_data to register cfg_index (0 mono_mode,
// 1 min_velocity) at once; write only while no event is in flight.
// The back end loads each event, walks the 6-entry slot table serially, one
// slot at a time, then updates it; it takes a new event only after that update.
// Soft presses are dropped in the front end and never reach the back end.
// A two-entry command queue lets the input side keep accepting while the back
// end walks; a stalled result holds the back end in its update step.
// Reset clears both queues, all slots to released, the pointer and config.
// ----------------------------------------------------------------------------
module synth_voice_allocator (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     push,
    output logic                                     full,
    input  svalloc_pkg::key_event_t                  key_event,
    output logic                                     empty,
    input  logic                                     pop,
    output svalloc_pkg::voice_event_t                voice_event,
    input  logic                                     cfg_we,
    input  logic [svalloc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [svalloc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import svalloc_pkg::*;

    logic             mono_mode_reg;
    logic [VEL_W-1:0] min_velocity_reg;
    logic             cmd_valid;
    cmd_t             cmd;
    logic             cmd_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mono_mode_reg    <= 1'b0;
            min_velocity_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MONO_MODE:    mono_mode_reg    <= cfg_data[0];
                CFG_MIN_VELOCITY: min_velocity_reg <= cfg_data[VEL_W-1:0];
                default:          ;
            endcase
        end
    end

    svalloc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .key_event    (key_event),
        .min_velocity (min_velocity_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_take     (cmd_take)
    );

    svalloc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_take    (cmd_take),
        .mono_mode   (mono_mode_reg),
        .empty       (empty),
        .pop         (pop),
        .voice_event (voice_event)
    );

endmodule

/* rtl/core/svalloc_checker.sv */
// ----------------------------------------------------------------------------
// svalloc_checker
// Port-level checks on the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "synth_voice_allocator_assert.svh"

module svalloc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                full,
    input logic                                empty,
    input logic                                pop,
    input svalloc_pkg::voice_event_t           voice_event
);
    import svalloc_pkg::*;

    logic held_out;
    logic stalled;

    assign held_out = !empty && (voice_event.event_kind == KIND_HELD);
    assign stalled  = !empty && !pop;

    // both queues are drained by the next clock edge in reset
    `SVALLOC_ASSERT_RST(a_reset_drained, !rst_n |=> empty && !full, "queues not clear in reset")

    // results only name voices that exist
    `SVALLOC_ASSERT(a_voice_range, !empty |-> voice_event.voice < VOICE_W'(VOICES), "bad voice")

    // a no-retrigger event is only ever sent to voice 0
    `SVALLOC_ASSERT(a_held_voice0, held_out |-> voice_event.voice == '0, "held event off voice 0")

    // a waiting result holds until it is taken
    `SVALLOC_ASSERT(a_result_hold, stalled |=> !empty && $stable(voice_event), "result moved")

endmodule

bind synth_voice_allocator svalloc_checker u_checker (.*);

/* tb/synth_voice_allocator_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Voice allocator checker
// Watches key event and voice event transfers and register writes, keeps its
// own slot table and round-robin pointer, and compares every popped voice
// event field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module synth_voice_allocator_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  logic                               full,
    input  svalloc_pkg::key_event_t            key_event,
    input  logic                               empty,
    input  logic                               pop,
    input  svalloc_pkg::voice_event_t          voice_event,
    input  logic                               cfg_we,
    input  logic [svalloc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [svalloc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 checked_count
);
    import svalloc_pkg::*;

    slot_t             slots [VOICES];
    int unsigned       rr_ptr;
    logic              mono;
    logic [VEL_W-1:0]  vel_floor;
    voice_event_t      predicted_events [$];

    function automatic slot_t mk_slot(logic [KIND_W-1:0] kind, logic [NOTE_W-1:0] note,
                                      logic [VEL_W-1:0] velocity);
        slot_t s;
        s.kind     = kind;
        s.note     = note;
        s.velocity = velocity;
        return s;
    endfunction

    function automatic voice_event_t voice_result(int v, logic [KIND_W-1:0] kind,
                                                  logic [NOTE_W-1:0] note,
                                                  logic [VEL_W-1:0] velocity);
        voice_event_t r;
        r.voice        = v[VOICE_W-1:0];
        r.event_kind   = kind;
        r.out_note     = note;
        r.out_velocity = velocity;
        return r;
    endfunction

    // first released slot among the parking slots 1 and up
    function automatic int free_parking();
        int p;
        p = -1;
        for (int i = VOICES - 1; i >= 1; i--)
            if (slots[i].kind == KIND_RELEASED)
                p = i;
        return p;
    endfunction

    task automatic allocate(input key_event_t ev, output bit hit, output voice_event_t res);
        int found;
        int p;
        int best;
        logic [NOTE_W-1:0] best_note;
        hit = 1'b0;
        res = '0;
        if (ev.key_down && ev.velocity <= vel_floor)
        begin
            // soft press: dropped
        end
        else if (!mono)
        begin
            found = -1;
            for (int i = 0; i < VOICES; i++)
                if (found < 0 && slots[i].kind == KIND_PRESSED &&
                    slots[i].note == ev.note)
                    found = i;
            if (ev.key_down)
            begin
                if (found < 0)
                begin
                    if (rr_ptr >= VOICES)
                        rr_ptr = 0;
                    // skip pressed slots; a full table wraps back to the start slot
                    for (int n = 0; n < VOICES && slots[rr_ptr].kind == KIND_PRESSED; n++)
                        rr_ptr = (rr_ptr + 1) % VOICES;
                    found = rr_ptr;
                    rr_ptr = (rr_ptr + 1) % VOICES;
                end
                slots[found] = mk_slot(KIND_PRESSED, ev.note, ev.velocity);
                res = voice_result(found, KIND_PRESSED, ev.note, ev.velocity);
                hit = 1'b1;
            end
            else if (found >= 0)
            begin
                slots[found] = mk_slot(KIND_RELEASED, ev.note, ev.velocity);
                res = voice_result(found, KIND_RELEASED, ev.note, ev.velocity);
                hit = 1'b1;
            end
        end
        else if (ev.key_down)
        begin
            if (slots[0].kind == KIND_RELEASED)
            begin
                slots[0] = mk_slot(KIND_PRESSED, ev.note, ev.velocity);
                res = voice_result(0, KIND_PRESSED, ev.note, ev.velocity);
                hit = 1'b1;
            end
            else if (slots[0].note < ev.note)
            begin
                p = free_parking();
                if (p >= 0)
                    slots[p] = mk_slot(KIND_HELD, slots[0].note, slots[0].velocity);
                slots[0] = mk_slot(KIND_HELD, ev.note, ev.velocity);
                res = voice_result(0, KIND_HELD, ev.note, ev.velocity);
                hit = 1'b1;
            end
            else if (slots[0].note > ev.note)
            begin
                p = free_parking();
                if (p >= 0)
                    slots[p] = mk_slot(KIND_HELD, ev.note, ev.velocity);
            end
        end
        else
        begin
            found = -1;
            for (int i = 0; i < VOICES; i++)
                if (found < 0 && slots[i].kind != KIND_RELEASED &&
                    slots[i].note == ev.note)
                    found = i;
            if (found == 0)
            begin
                best = -1;
                best_note = '0;
                for (int j = 1; j < VOICES; j++)
                    if (slots[j].kind == KIND_HELD &&
                        (best < 0 || slots[j].note > best_note))
                    begin
                        best = j;
                        best_note = slots[j].note;
                    end
                if (best > 0)
                begin
                    // highest held note moves up to voice 0
                    slots[best].kind = KIND_RELEASED;
                    slots[0] = mk_slot(KIND_HELD, slots[best].note, slots[best].velocity);
                    res = voice_result(0, KIND_HELD, slots[0].note, slots[0].velocity);
                end
                else
                begin
                    slots[0] = mk_slot(KIND_RELEASED, ev.note, ev.velocity);
                    res = voice_result(0, KIND_RELEASED, ev.note, ev.velocity);
                end
                hit = 1'b1;
            end
            else if (found > 0)
            begin
                slots[found] = mk_slot(KIND_RELEASED, ev.note, ev.velocity);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        bit           hit;
        voice_event_t res;
        voice_event_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
                slots[i] = mk_slot(KIND_RELEASED, '0, '0);
            rr_ptr        = 0;
            mono          = 1'b0;
            vel_floor     = '0;
            predicted_events.delete();
            fail_count    = 0;
            pending       = 0;
            checked_count = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (predicted_events.size() == 0)
                begin
                    $error("unexpected voice event: voice %0d kind %0d note %0d velocity %0d",
                           voice_event.voice, voice_event.event_kind,
                           voice_event.out_note, voice_event.out_velocity);
                    fail_count++;
                end
                else
                begin
                    want = predicted_events.pop_front();
                    checked_count++;
                    if (voice_event.voice !== want.voice)
                    begin
                        $error("voice: expected %0d, actual %0d", want.voice, voice_event.voice);
                        fail_count++;
                    end
                    if (voice_event.event_kind !== want.event_kind)
                    begin
                        $error("event_kind: expected %0d, actual %0d",
                               want.event_kind, voice_event.event_kind);
                        fail_count++;
                    end
                    if (voice_event.out_note !== want.out_note)
                    begin
                        $error("out_note: expected %0d, actual %0d",
                               want.out_note, voice_event.out_note);
                        fail_count++;
                    end
                    if (voice_event.out_velocity !== want.out_velocity)
                    begin
                        $error("out_velocity: expected %0d, actual %0d",
                               want.out_velocity, voice_event.out_velocity);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MONO_MODE:    mono      = cfg_data[0];
                    CFG_MIN_VELOCITY: vel_floor = cfg_data[VEL_W-1:0];
                    default: ;
                endcase
            end
            if (push && !full)
            begin
                allocate(key_event, hit, res);
                if (hit)
                    predicted_events.push_back(res);
            end
            pending = predicted_events.size();
        end
    end

endmodule

/* tb/synth_voice_allocator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Voice allocator testbench
// Drives key events and register writes into the allocator, pops voice events
// with random gaps and one long hold, and leaves prediction and comparison to
// the checker beside the block. Directed cases first, then random phases over
// several poly and mono settings with well-formed press/release sequences.
// ----------------------------------------------------------------------------
module synth_voice_allocator_test;
    import svalloc_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;    // two queued events plus one in the walk
    localparam int STALL_LIMIT  = 4000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    logic                  pop       = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    key_event_t            key_event = '0;
    logic                  full;
    logic                  empty;
    voice_event_t          voice_event;

    int fail_count;
    int pending;
    int checked_count;
    int sent_count     = 0;
    int settings_count = 0;
    int stall_cycles   = 0;
    bit tx_idle        = 1'b1;
    bit rx_idle        = 1'b1;
    bit hold_req       = 1'b0;

    logic [NOTE_W-1:0] down_keys [$];
    logic [NOTE_W-1:0] key_base = '0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    synth_voice_allocator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .key_event   (key_event),
        .empty       (empty),
        .pop         (pop),
        .voice_event (voice_event),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    synth_voice_allocator_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .key_event     (key_event),
        .empty         (empty),
        .pop           (pop),
        .voice_event   (voice_event),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count)
    );

    // watchdog: cycles without any transfer or register write
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || cfg_we || !rst_n)
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // result side: random gap per voice event, one long hold on request
    initial
    begin : receiver
        int wait_cycles;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req    = 1'b0;
                wait_cycles = HOLD_CYCLES;
            end
            else
                wait_cycles = rx_idle ? $urandom_range(0, 4) : 0;
            if (wait_cycles > 0)
            begin
                pop <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
        end
    end

    function automatic key_event_t kev(bit down, int note, int velocity);
        key_event_t ev;
        ev.key_down = down;
        ev.note     = note[NOTE_W-1:0];
        ev.velocity = velocity[VEL_W-1:0];
        return ev;
    endfunction

    // entered and left at a falling edge
    task automatic send_key(input key_event_t ev);
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push      <= 1'b1;
        key_event <= ev;
        @(posedge clk);
        while (full) @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    // wait until every voice event is out and the back end has gone quiet
    task automatic settle();
        push <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(input bit mono, input logic [VEL_W-1:0] vel_floor);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MONO_MODE;
        cfg_data  <= CFG_DATA_W'(mono);
        @(negedge clk);
        cfg_index <= CFG_MIN_VELOCITY;
        cfg_data  <= CFG_DATA_W'(vel_floor);
        @(negedge clk);
        cfg_we    <= 1'b0;
        settings_count++;
    endtask

    // mostly presses from a small key range and releases of keys still down,
    // with some fully random notes and soft presses as noise
    task automatic next_key(input logic [VEL_W-1:0] vel_floor, output key_event_t ev);
        int idx;
        logic [NOTE_W-1:0] n;
        if (vel_floor < 127 && $urandom_range(0, 99) < 85)
            ev.velocity = VEL_W'($urandom_range(vel_floor + 1, 127));
        else
            ev.velocity = VEL_W'($urandom_range(0, 127));
        if (down_keys.size() > 10 ||
            $urandom_range(0, 99) < (down_keys.size() > 0 ? 45 : 5))
        begin
            ev.key_down = 1'b0;
            if (down_keys.size() > 0 && $urandom_range(0, 99) < 85)
            begin
                idx     = $urandom_range(0, down_keys.size() - 1);
                ev.note = down_keys[idx];
                down_keys.delete(idx);
            end
            else
                ev.note = NOTE_W'($urandom_range(0, 127));
        end
        else
        begin
            ev.key_down = 1'b1;
            if ($urandom_range(0, 99) < 85)
                n = NOTE_W'(key_base + $urandom_range(0, 11));
            else
                n = NOTE_W'($urandom_range(0, 127));
            ev.note = n;
            if (ev.velocity > vel_floor)
                down_keys.push_back(n);
        end
    endtask

    task automatic run_phase(input bit mono, input logic [VEL_W-1:0] vel_floor,
                             input int count, input bit with_hold);
        key_event_t ev;
        settle();
        set_config(mono, vel_floor);
        key_base = NOTE_W'($urandom_range(0, 116));
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
            begin
                tx_idle = ($urandom_range(0, 2) != 0);
                rx_idle = ($urandom_range(0, 2) != 0);
            end
            // result side stops while keys keep coming, so the input backs up
            if (with_hold && i == 20)
                hold_req = 1'b1;
            next_key(vel_floor, ev);
            send_key(ev);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // poly, reset settings: extremes, soft press, repeat press, unknown release
        send_key(kev(1, 0, 127));
        send_key(kev(1, 127, 1));
        send_key(kev(1, 60, 0));
        send_key(kev(1, 127, 5));
        send_key(kev(0, 99, 127));
        send_key(kev(0, 0, 0));
        // fill every slot, then one more takes over the pointer slot
        for (int n = 10; n <= 14; n++)
            send_key(kev(1, n, 64 + n));
        send_key(kev(1, 16, 100));
        settle();
        set_config(1'b0, 7'd127);
        send_key(kev(1, 50, 127));

        // mono: parked release, equal, lower, higher with full parking,
        // release to held note, release with nothing held, unknown release
        settle();
        set_config(1'b1, 7'd0);
        send_key(kev(0, 16, 33));
        send_key(kev(1, 14, 90));
        send_key(kev(1, 5, 20));
        send_key(kev(1, 20, 110));
        send_key(kev(0, 20, 1));
        send_key(kev(0, 5, 126));
        send_key(kev(0, 99, 50));
        send_key(kev(1, 127, 127));
        send_key(kev(1, 0, 1));
        send_key(kev(0, 127, 0));

        run_phase(1'b0, 7'd0,   420, 1'b1);
        run_phase(1'b1, 7'd0,   420, 1'b0);
        run_phase(1'b0, 7'd64,  330, 1'b0);
        run_phase(1'b1, 7'd127,  40, 1'b0);
        run_phase(1'b1, 7'd30,  380, 1'b0);
        run_phase(1'b0, 7'd127,  40, 1'b0);
        run_phase(1'b0, 7'd5,   220, 1'b0);
        settle();

        $display("Sent %0d key events over %0d register settings in poly and mono modes",
                 sent_count, settings_count + 1);
        $display("Checked %0d voice events, with one %0d-cycle hold backing up the input",
                 checked_count, HOLD_CYCLES);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
